FILE: rtl/core/elb_pkg.sv
// ----------------------------------------------------------------------------
// elb_pkg
// Types and constants shared by the embedding lookup block.
// ----------------------------------------------------------------------------
package elb_pkg;

   localparam int DIM_CNT_W   = 7;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = 2;
   localparam int FIFO_CNT_W  = 3;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_PADDING_INDEX  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_COUNT     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIMS_IN_USE    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TWO_DIRECTIONS = 8'd3;

   typedef struct packed {
      logic               operation;
      logic [11:0]        load_row;
      logic [5:0]         load_column;
      logic [31:0]        load_value;
      logic signed [15:0] word_id;
      logic [15:0]        word_position;
      logic [15:0]        sequence_start;
      logic [16:0]        sequence_end;
   } req_type;

   typedef struct packed {
      logic [5:0]  element_index;
      logic [31:0] element_value;
      logic [15:0] forward_position;
      logic [15:0] reverse_position;
      logic        id_error;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic signed [12:0] padding_index;
      logic [12:0]        word_count;
      logic [6:0]         dims_in_use;
      logic               two_directions;
   } cfg_type;

endpackage

FILE: rtl/core/elb_ram.sv
// ----------------------------------------------------------------------------
// elb_ram
// Generic single-port RAM, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module elb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/elb_rsp_fifo.sv
// ----------------------------------------------------------------------------
// elb_rsp_fifo
// Small response queue between the table read and the response channel.
// ----------------------------------------------------------------------------
module elb_rsp_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  elb_pkg::rsp_type                   push_data,
   output logic [elb_pkg::FIFO_CNT_W-1:0]     count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output elb_pkg::rsp_type                   rsp_data
);

   elb_pkg::rsp_type                    entry_ff [elb_pkg::FIFO_DEPTH];
   logic [elb_pkg::FIFO_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [elb_pkg::FIFO_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [elb_pkg::FIFO_CNT_W-1:0]      count_ff, count_in;
   logic                                pop;

   assign pop       = rsp_valid && rsp_ready;
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + elb_pkg::FIFO_CNT_W'(push) - elb_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign count     = count_ff;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/elb_seq.sv
// ----------------------------------------------------------------------------
// elb_seq
// Request sequencer: table loads, lookup decode and per-element row reads.
// ----------------------------------------------------------------------------
module elb_seq #(
   parameter int MAX_WORDS    = 4096,
   parameter int MAX_DIMS     = 64,
   parameter int ELEMENT_BITS = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  elb_pkg::cfg_type                            cfg,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  elb_pkg::req_type                            req_data,
   output logic                                        mem_we,
   output logic [$clog2(MAX_WORDS*MAX_DIMS)-1:0]       mem_addr,
   output logic [ELEMENT_BITS-1:0]                     mem_wdata,
   input  logic [ELEMENT_BITS-1:0]                     mem_rdata,
   input  logic [elb_pkg::FIFO_CNT_W-1:0]              fifo_count,
   output logic                                        push,
   output elb_pkg::rsp_type                            push_data
);

   localparam int DEPTH = MAX_WORDS * MAX_DIMS;
   localparam int AW    = $clog2(DEPTH);
   localparam int ROW_W = $clog2(MAX_WORDS);
   localparam int DW    = elb_pkg::DIM_CNT_W;

   typedef enum logic {
      IDLE,
      BUSY
   } state_type;

   state_type               state_ff;
   logic [AW-1:0]           base_ff;
   logic [DW-1:0]           col_ff;
   logic [DW-1:0]           dims_ff;
   logic                    zero_ff;
   logic                    err_ff;
   logic [15:0]             pos_ff;
   logic [15:0]             rev_ff;
   logic                    pend_ff;
   logic [5:0]              pend_idx_ff;
   logic                    pend_last_ff;
   logic                    pend_zero_ff;
   logic                    pend_err_ff;
   logic [15:0]             pend_pos_ff;
   logic [15:0]             pend_rev_ff;

   logic                    accept;
   logic                    load_we;
   logic [AW-1:0]           wr_addr;
   logic                    issue;
   logic                    is_last;
   logic signed [15:0]      pad_ext;
   logic [16:0]             limit;
   logic                    is_pad;
   logic                    is_err;
   logic [DW-1:0]           dims_in;
   logic [15:0]             rev_in;
   logic [AW-1:0]           base_in;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;
   assign load_we   = accept && (req_data.operation == elb_pkg::OP_LOAD)
                      && (17'(req_data.load_row) < 17'(MAX_WORDS))
                      && (7'(req_data.load_column) < 7'(MAX_DIMS));
   assign wr_addr   = AW'(req_data.load_row) * AW'(MAX_DIMS) + AW'(req_data.load_column);

   always_comb begin
      pad_ext = {{3{cfg.padding_index[12]}}, cfg.padding_index};
      limit   = (17'(cfg.word_count) < 17'(MAX_WORDS)) ? 17'(cfg.word_count)
                                                       : 17'(MAX_WORDS);
      is_pad  = (req_data.word_id == pad_ext);
      is_err  = !is_pad && (req_data.word_id[15]
                || (17'($unsigned(req_data.word_id)) >= limit));
      if (cfg.dims_in_use == '0) begin
         dims_in = DW'(1);
      end else if (cfg.dims_in_use > DW'(MAX_DIMS)) begin
         dims_in = DW'(MAX_DIMS);
      end else begin
         dims_in = cfg.dims_in_use;
      end
      rev_in  = cfg.two_directions
                ? 16'(req_data.sequence_start + req_data.sequence_end[15:0] - 16'd1
                      - req_data.word_position)
                : 16'd0;
      base_in = (is_pad || is_err) ? '0
                : AW'(req_data.word_id[ROW_W-1:0]) * AW'(MAX_DIMS);
   end

   assign issue   = (state_ff == BUSY)
                    && ((4'(fifo_count) + 4'(pend_ff)) < 4'(elb_pkg::FIFO_DEPTH));
   assign is_last = ((col_ff + DW'(1)) == dims_ff);

   assign mem_we    = load_we;
   assign mem_addr  = load_we ? wr_addr : base_ff + AW'(col_ff);
   assign mem_wdata = req_data.load_value[ELEMENT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= issue;
         unique case (state_ff)
            IDLE: begin
               if (accept && (req_data.operation == elb_pkg::OP_LOOKUP)) begin
                  state_ff <= BUSY;
               end
            end
            BUSY: begin
               if (issue && is_last) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
      if (accept) begin
         base_ff <= base_in;
         col_ff  <= '0;
         dims_ff <= dims_in;
         zero_ff <= is_pad || is_err;
         err_ff  <= is_err;
         pos_ff  <= req_data.word_position;
         rev_ff  <= rev_in;
      end else if (issue) begin
         col_ff <= col_ff + DW'(1);
      end
      if (issue) begin
         pend_idx_ff  <= col_ff[5:0];
         pend_last_ff <= is_last;
         pend_zero_ff <= zero_ff;
         pend_err_ff  <= err_ff;
         pend_pos_ff  <= pos_ff;
         pend_rev_ff  <= rev_ff;
      end
   end

   assign push = pend_ff;

   always_comb begin
      push_data.element_index    = pend_idx_ff;
      push_data.element_value    = pend_zero_ff ? 32'd0 : 32'(mem_rdata);
      push_data.forward_position = pend_pos_ff;
      push_data.reverse_position = pend_rev_ff;
      push_data.id_error         = pend_err_ff;
      push_data.last             = pend_last_ff;
   end

endmodule

FILE: rtl/core/embedding_lookup_bidir_unit.sv
// ----------------------------------------------------------------------------
// embedding_lookup_bidir_unit
// Embedding table engine with padding index and mirrored sequence positions.
// ----------------------------------------------------------------------------
// A load request writes one table element, if in range, and returns nothing.
// A lookup request returns dims_in_use responses (clamped to 1..MAX_DIMS),
// one element per cycle while the queue has room, and no request is taken
// meanwhile; the table's single port sets this rate. Responses wait in a
// four-entry queue, so a stalled response side slows the reads but loses
// nothing. The table has no reset; rows must be loaded before they are read.
module embedding_lookup_bidir_unit #(
   parameter int MAX_WORDS    = 4096,
   parameter int MAX_DIMS     = 64,
   parameter int ELEMENT_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  elb_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output elb_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [elb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [elb_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int DEPTH = MAX_WORDS * MAX_DIMS;
   localparam int AW    = $clog2(DEPTH);

   elb_pkg::cfg_type                    cfg_ff;
   logic                                mem_we;
   logic [AW-1:0]                       mem_addr;
   logic [ELEMENT_BITS-1:0]             mem_wdata;
   logic [ELEMENT_BITS-1:0]             mem_rdata;
   logic [elb_pkg::FIFO_CNT_W-1:0]      fifo_count;
   logic                                push;
   elb_pkg::rsp_type                    push_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.padding_index  <= -13'sd1;
         cfg_ff.word_count     <= 13'd4096;
         cfg_ff.dims_in_use    <= 7'd64;
         cfg_ff.two_directions <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            elb_pkg::CSR_PADDING_INDEX:  cfg_ff.padding_index  <= csr_data[12:0];
            elb_pkg::CSR_WORD_COUNT:     cfg_ff.word_count     <= csr_data[12:0];
            elb_pkg::CSR_DIMS_IN_USE:    cfg_ff.dims_in_use    <= csr_data[6:0];
            elb_pkg::CSR_TWO_DIRECTIONS: cfg_ff.two_directions <= csr_data[0];
            default: ;
         endcase
      end
   end

   elb_seq #(
      .MAX_WORDS    (MAX_WORDS),
      .MAX_DIMS     (MAX_DIMS),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .mem_we     (mem_we),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata),
      .fifo_count (fifo_count),
      .push       (push),
      .push_data  (push_data)
   );

   elb_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   elb_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .count     (fifo_count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/elb_checker.sv
// ----------------------------------------------------------------------------
// elb_checker
// Port-level checks for the embedding lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module elb_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  elb_pkg::req_type  req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  elb_pkg::rsp_type  rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.id_error |-> rsp_data.element_value == 32'd0)
      else $error("invalid id returned nonzero element");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.operation == elb_pkg::OP_LOOKUP)
      |=> !req_ready)
      else $error("request taken while lookup in progress");

endmodule

bind embedding_lookup_bidir_unit elb_checker u_elb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
